// ===== rtl/core/u8dec_pkg.sv =====
package u8dec_pkg;

    localparam logic [7:0] C_ASCII_LIM = 8'h80;
    localparam logic [7:0] C_LEAD_MASK = 8'hE0;
    localparam logic [7:0] C_LEAD3     = 8'hE0;
    localparam logic [7:0] C_LEAD2     = 8'hC0;
    localparam logic [7:0] C_CONT_MASK = 8'hC0;
    localparam logic [7:0] C_CONT      = 8'h80;

    // one result: code unit plus its framing flags
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        stream_last;
    } t_res;

    typedef logic [7:0] t_byte;

    function automatic logic is_cont(input t_byte b);
        is_cont = (b & C_CONT_MASK) == C_CONT;
    endfunction

endpackage

// ===== rtl/core/u8dec_decode.sv =====
module u8dec_decode (
    input  u8dec_pkg::t_byte        i_pend [2],
    input  logic [1:0]              i_pcnt,
    input  u8dec_pkg::t_byte        i_byte,
    input  logic                    i_end,
    output u8dec_pkg::t_res [2:0]   o_res,
    output logic [1:0]              o_k,
    output u8dec_pkg::t_byte        o_pend [2],
    output logic [1:0]              o_pcnt
);
    import u8dec_pkg::*;

    t_byte       win [5];
    logic [1:0]  n;
    logic [2:0]  pos;
    logic [2:0]  rem;
    logic [1:0]  k;
    logic [1:0]  avail;
    logic        stop;
    logic        brk;
    logic [1:0]  used;
    logic [15:0] cu;
    t_byte       b0;
    t_byte       b1;
    t_byte       b2;

    always_comb begin
        win[0] = (i_pcnt != 2'd0) ? i_pend[0] : i_byte;
        win[1] = (i_pcnt == 2'd2) ? i_pend[1] : ((i_pcnt == 2'd1) ? i_byte : 8'h00);
        win[2] = (i_pcnt == 2'd2) ? i_byte : 8'h00;
        win[3] = 8'h00;
        win[4] = 8'h00;
        n      = i_pcnt + 2'd1;
        pos    = 3'd0;
        k      = 2'd0;
        stop   = 1'b0;
        avail  = 2'd0;
        brk    = 1'b0;
        used   = 2'd1;
        cu     = 16'h0000;
        b0     = 8'h00;
        b1     = 8'h00;
        b2     = 8'h00;
        o_res  = '0;

        // at most three resolution steps over the three-byte window
        for (int it = 0; it < 3; it++) begin
            if (!stop && (pos < {1'b0, n})) begin
                avail = n - pos[1:0];
                b0    = win[pos];
                b1    = win[pos + 3'd1];
                b2    = win[pos + 3'd2];
                cu    = {8'h00, b0};
                used  = 2'd1;
                brk   = 1'b0;
                if (b0 < C_ASCII_LIM) begin
                    brk = 1'b0;
                end else if ((b0 & C_LEAD_MASK) == C_LEAD3) begin
                    if (avail >= 2'd2 && !is_cont(b1)) begin
                        brk = 1'b0;
                    end else if (avail < 2'd3) begin
                        brk = !i_end;
                    end else if (is_cont(b2)) begin
                        cu   = {b0[3:0], b1[5:0], b2[5:0]};
                        used = 2'd3;
                    end
                end else if ((b0 & C_LEAD_MASK) == C_LEAD2) begin
                    if (avail < 2'd2) begin
                        brk = !i_end;
                    end else if (is_cont(b1)) begin
                        cu   = {5'd0, b0[4:0], b1[5:0]};
                        used = 2'd2;
                    end
                end
                if (brk) begin
                    stop = 1'b1;
                end else begin
                    o_res[it].code_unit = cu;
                    k   = k + 2'd1;
                    pos = pos + {1'b0, used};
                end
            end
        end

        // flag the last result of this byte
        for (int j = 0; j < 3; j++) begin
            o_res[j].run_last    = (k == 2'(j + 1));
            o_res[j].stream_last = (k == 2'(j + 1)) && i_end;
        end

        rem       = {1'b0, n} - pos;
        o_pcnt    = rem[1:0];
        o_pend[0] = win[pos];
        o_pend[1] = win[pos + 3'd1];
        o_k       = k;
    end

endmodule

// ===== rtl/core/u8dec_obuf.sv =====
module u8dec_obuf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  u8dec_pkg::t_res [2:0]  i_res,
    input  logic [1:0]             i_k,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_ready,
    output u8dec_pkg::t_res        o_res
);
    import u8dec_pkg::*;

    t_res [2:0] r_q;
    t_res [2:0] n_q;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    // empty after this cycle's transfer, so a new group may be loaded
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[0];

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_load) begin
            n_q   = i_res;
            n_cnt = i_k;
        end else if (pop) begin
            n_q   = {r_q[2], r_q[2:1]};
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/utf8_to_utf16_bmp_decoder.sv =====
// Path: a byte's results are decoded combinationally from the input register and
// the held bytes, then loaded into the output buffer register when it has room.
// Throughput: one byte per cycle while the output buffer has room; a byte that releases k
// results holds the buffer for k output transfers, and the next byte waits in the input register.
// Reset (synchronous, active low) clears the pending count and both valid
// flags; held pending bytes are left as they are.
module utf8_to_utf16_bmp_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_run_last,
    output logic        o_stream_last
);
    import u8dec_pkg::*;

    logic       r_in_vld;
    t_byte      r_in_byte;
    logic       r_in_end;
    t_byte      r_pend [2];
    logic [1:0] r_pcnt;

    t_res [2:0] dec_res;
    logic [1:0] dec_k;
    t_byte      dec_pend [2];
    logic [1:0] dec_pcnt;
    logic       room;
    logic       adv;
    t_res       out_res;

    u8dec_decode u_dec (
        .i_pend (r_pend),
        .i_pcnt (r_pcnt),
        .i_byte (r_in_byte),
        .i_end  (r_in_end),
        .o_res  (dec_res),
        .o_k    (dec_k),
        .o_pend (dec_pend),
        .o_pcnt (dec_pcnt)
    );

    u8dec_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (dec_res),
        .i_k     (dec_k),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    // advance the held byte once the buffer drains
    assign adv     = r_in_vld && room;
    assign o_ready = !r_in_vld || adv;

    assign o_code_unit   = out_res.code_unit;
    assign o_run_last    = out_res.run_last;
    assign o_stream_last = out_res.stream_last;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_stream_end;
        end
        if (adv) begin
            r_pend[0] <= dec_pend[0];
            r_pend[1] <= dec_pend[1];
        end
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_pcnt   <= 2'd0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (adv) begin
                r_pcnt <= dec_pcnt;
            end
        end
    end

endmodule

// ===== rtl/core/u8dec_chk.sv =====
module u8dec_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_code_unit,
    input logic        o_run_last,
    input logic        o_stream_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_unit)
            && $stable(o_stream_last))
        else $error("stalled result changed");

    // the end of the stream is always the end of a byte's run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_last |-> o_run_last)
        else $error("stream_last without run_last");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind utf8_to_utf16_bmp_decoder u8dec_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code_unit   (o_code_unit),
    .o_run_last    (o_run_last),
    .o_stream_last (o_stream_last)
);

// ===== sim/tb_utf8_to_utf16_bmp_decoder.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_utf16_bmp_decoder;
    import u8dec_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 420;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte    = 8'h00;
    logic        i_stream_end = 1'b0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_run_last;
    logic        o_stream_last;

    // decoder state as predicted from the accepted bytes
    logic [7:0]  held_bytes [2];
    int          held_cnt = 0;

    t_res        units_q [$];
    t_res        want_unit;
    int          fail_cnt   = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    t_rx_mode    rx_mode  = RX_OPEN;
    int          rx_phase = 0;
    int          rx_tick  = 0;

    utf8_to_utf16_bmp_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_stream_end  (i_stream_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_unit   (o_code_unit),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic trail_byte(input logic [7:0] b);
        return (b & C_CONT_MASK) == C_CONT;
    endfunction

    // Work out the code units released by one byte and queue them.
    function automatic void predict_units(input logic [7:0] b, input logic fin);
        logic [7:0]  win [3];
        logic [7:0]  b0;
        logic [15:0] cu;
        logic        stop;
        int          n;
        int          pos;
        int          k;
        int          used;
        int          avail;
        int          i;
        t_res        unit;
        n    = 0;
        pos  = 0;
        k    = 0;
        stop = 1'b0;
        for (i = 0; i < held_cnt; i++) begin
            win[n] = held_bytes[i];
            n++;
        end
        win[n] = b;
        n++;
        while (pos < n && k < 3 && !stop) begin
            avail = n - pos;
            b0    = win[pos];
            cu    = {8'h00, b0};
            used  = 1;
            if (b0 < C_ASCII_LIM) begin
                // plain byte
            end else if ((b0 & C_LEAD_MASK) == C_LEAD3) begin
                if (avail >= 2 && !trail_byte(win[pos + 1])) begin
                    // early failure: lead goes out raw
                end else if (avail < 3) begin
                    stop = !fin;
                end else if (trail_byte(win[pos + 2])) begin
                    cu   = {b0[3:0], win[pos + 1][5:0], win[pos + 2][5:0]};
                    used = 3;
                end
            end else if ((b0 & C_LEAD_MASK) == C_LEAD2) begin
                if (avail < 2) begin
                    stop = !fin;
                end else if (trail_byte(win[pos + 1])) begin
                    cu   = {5'b00000, b0[4:0], win[pos + 1][5:0]};
                    used = 2;
                end
            end
            if (!stop) begin
                unit.code_unit   = cu;
                unit.run_last    = 1'b0;
                unit.stream_last = 1'b0;
                units_q.push_back(unit);
                k++;
                pos += used;
            end
        end
        for (i = 0; pos + i < n && i < 2; i++)
            held_bytes[i] = win[pos + i];
        held_cnt = i;
        if (k > 0) begin
            units_q[$].run_last    = 1'b1;
            units_q[$].stream_last = fin;
        end
    endfunction

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Drive one byte, hold it until the transfer, then predict its results.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_in_byte    <= b;
        i_stream_end <= fin;
        do @(posedge i_clk); while (!o_ready);
        predict_units(b, fin);
        bytes_sent++;
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (units_q.size() != 0);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_two_byte();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_three_byte();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        // leads from 0xF0 up take the three-byte path
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_stray_trail();
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hE5, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // second trail byte missing: three units from one byte
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_stream_flush();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC5, 1'b1);
    endtask

    task automatic test_random_stream();
        int          kind;
        int          stop_at;
        int          half_at;
        logic        drained;
        logic [7:0]  lead;
        logic [7:0]  junk;
        stop_at = bytes_sent + RANDOM_BYTES;
        half_at = bytes_sent + RANDOM_BYTES / 2;
        drained = 1'b0;
        while (bytes_sent < stop_at) begin
            if (!drained && bytes_sent >= half_at) begin
                pause_until_drained();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            junk = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                        : 8'(8'hC0 | $urandom_range(0, 63));
            if (kind < 25) begin
                send_byte(8'($urandom_range(0, 8'h7F)), $urandom_range(0, 24) == 0);
            end else if (kind < 45) begin
                send_byte(8'(8'hC0 | $urandom_range(0, 31)), $urandom_range(0, 24) == 0);
                send_byte(8'(8'h80 | $urandom_range(0, 63)), $urandom_range(0, 24) == 0);
            end else if (kind < 72) begin
                send_byte(8'(8'hE0 | $urandom_range(0, 31)), $urandom_range(0, 24) == 0);
                send_byte(8'(8'h80 | $urandom_range(0, 63)), $urandom_range(0, 24) == 0);
                send_byte(8'(8'h80 | $urandom_range(0, 63)), $urandom_range(0, 24) == 0);
            end else if (kind < 80) begin
                send_byte(8'(8'h80 | $urandom_range(0, 63)), $urandom_range(0, 24) == 0);
            end else if (kind < 93) begin
                lead = (kind < 86) ? 8'(8'hC0 | $urandom_range(0, 31))
                                   : 8'(8'hE0 | $urandom_range(0, 31));
                send_byte(lead, 1'b0);
                if (kind >= 90)
                    send_byte(8'(8'h80 | $urandom_range(0, 63)), 1'b0);
                // break the sequence, or cut it short with the stream end
                if ($urandom_range(0, 3) == 0)
                    send_byte(8'(8'h80 | $urandom_range(0, 63)), 1'b1);
                else
                    send_byte(junk, $urandom_range(0, 9) == 0);
            end else begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
            end
        end
    endtask

    // compare each output transfer with the oldest expected code unit
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (units_q.size() == 0) begin
                note_fail($sformatf("unexpected unit %h run_last %b stream_last %b",
                                    o_code_unit, o_run_last, o_stream_last));
            end else begin
                want_unit = units_q.pop_front();
                if (o_code_unit !== want_unit.code_unit || o_run_last !== want_unit.run_last
                        || o_stream_last !== want_unit.stream_last)
                    note_fail($sformatf({"mismatch: unit %h/%h run_last %b/%b ",
                                         "stream_last %b/%b (expected/actual)"},
                                        want_unit.code_unit, o_code_unit,
                                        want_unit.run_last, o_run_last,
                                        want_unit.stream_last, o_stream_last));
            end
        end
    end

    // output stalls: switch at random between ready patterns
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_phase == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(0, 3));
            rx_phase <= $urandom_range(16, 96);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_OPEN:  i_ready <= 1'b1;
            RX_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_ready <= ($urandom_range(0, 3) == 0);
            default:  i_ready <= ((rx_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_bytes();
        test_two_byte();
        test_three_byte();
        test_stray_trail();
        test_broken_sequences();
        test_stream_flush();
        test_random_stream();
        pause_until_drained();
        repeat (10) @(posedge i_clk);
        if (units_q.size() != 0)
            note_fail($sformatf("%0d code units never arrived", units_q.size()));
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
